// File: src/bim_pkg.sv
// Shared constants for the broadcast index map.
package bim_pkg;

  localparam int NUM_DIM_REGS = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int REG_BITS     = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_DIM_0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_DIM_0 = 3'd4;

endpackage

// File: src/bim_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module bim_div_pipe #(
  parameter int N = 32,
  parameter int D = 32
) (
  input  logic         clk,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic [N-1:0] quotient,
  output logic [D-1:0] remainder
);

  logic [D-1:0] rem_q  [N];
  logic [N-1:0] work_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [D-1:0] rin;
    logic [N-1:0] win;
    logic [D:0]   t;
    logic [D:0]   diff;
    logic         ge;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign win = dividend;
    end else begin : g_next
      assign rin = rem_q[i-1];
      assign win = work_q[i-1];
    end

    assign t    = {rin, win[N-1]};
    assign diff = t - {1'b0, divisor};
    assign ge   = (t >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      rem_q[i]  <= ge ? diff[D-1:0] : t[D-1:0];
      work_q[i] <= {win[N-2:0], ge};
    end
  end

  assign quotient  = work_q[N-1];
  assign remainder = rem_q[N-1];

endmodule

// File: src/bim_shape.sv
// Shape registers, aligned dimensions, strides and shape check.
module bim_shape #(
  parameter int MAX_RANK = 4,
  parameter int IB       = 32,
  parameter int W        = 32,
  parameter int DW       = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bim_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bim_pkg::REG_BITS-1:0]  cfg_data,
  output logic [DW-1:0]                 od_eff     [MAX_RANK],
  output logic [DW-1:0]                 sd_al      [MAX_RANK],
  output logic [IB-1:0]                 out_stride [MAX_RANK],
  output logic [W-1:0]                  src_stride [MAX_RANK],
  output logic                          shape_err,
  output logic                          settling
);
  import bim_pkg::*;

  localparam int OFF    = MAX_RANK - NUM_DIM_REGS;
  localparam int CNT_W  = $clog2(MAX_RANK + 1);

  logic [DW-1:0]    od_reg [NUM_DIM_REGS];
  logic [DW-1:0]    sd_reg [NUM_DIM_REGS];
  logic [CNT_W-1:0] settle_cnt;
  logic [MAX_RANK-1:0] bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIM_REGS; i++) begin
        od_reg[i] <= DW'(1);
        sd_reg[i] <= DW'(1);
      end
      settle_cnt <= CNT_W'(MAX_RANK);
    end else begin
      if (cfg_we) begin
        settle_cnt <= CNT_W'(MAX_RANK);
        if (cfg_index < REG_SRC_DIM_0)
          od_reg[cfg_index[1:0]] <= cfg_data[DW-1:0];
        else
          sd_reg[cfg_index[1:0]] <= cfg_data[DW-1:0];
      end else if (settle_cnt != '0) begin
        settle_cnt <= settle_cnt - CNT_W'(1);
      end
    end
  end

  assign settling = (settle_cnt != '0);

  for (genvar p = 0; p < MAX_RANK; p++) begin : g_dim
    logic [DW-1:0] od_al;
    if (p - OFF >= 0 && p - OFF < NUM_DIM_REGS) begin : g_reg
      assign od_al    = od_reg[p - OFF];
      assign sd_al[p] = sd_reg[p - OFF];
    end else begin : g_one
      assign od_al    = DW'(1);
      assign sd_al[p] = DW'(1);
    end
    assign od_eff[p] = (od_al == '0) ? DW'(1) : od_al;
    assign bad[p]    = (sd_al[p] != DW'(1)) && (sd_al[p] != od_eff[p]);

    if (p == MAX_RANK - 1) begin : g_inner
      assign out_stride[p] = IB'(1);
      assign src_stride[p] = W'(1);
    end else begin : g_outer
      logic [IB+DW-1:0] oprod;
      logic [W+DW-1:0]  sprod;
      assign oprod = out_stride[p+1] * od_eff[p+1];
      assign sprod = src_stride[p+1] * sd_al[p+1];
      always_ff @(posedge clk) begin
        if (rst) begin
          out_stride[p] <= IB'(1);
          src_stride[p] <= W'(1);
        end else begin
          out_stride[p] <= oprod[IB-1:0];
          src_stride[p] <= sprod[W-1:0];
        end
      end
    end
  end

  assign shape_err = |bad;

endmodule

// File: src/broadcast_index_map_core.sv
// Broadcast index map: output flat index to source flat index.
//
// One item may start in every cycle while busy is low. Each result passes
// through an index register, two pipelined dividers per dimension lane
// (quotient by the output stride, then remainder by the output dimension),
// a product register and a sum register. Results come on done for one
// cycle and cannot be held off. After reset or any register write, busy
// stays high while the stride chain recomputes.
module broadcast_index_map_core #(
  parameter int MAX_RANK   = 4,
  parameter int INDEX_BITS = 32,
  parameter int DIM_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [31:0]                      flat_index,
  output logic                             done,
  output logic [31:0]                      source_index,
  output logic                             shape_error,
  input  logic                             cfg_we,
  input  logic [bim_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bim_pkg::REG_BITS-1:0]     cfg_data
);
  import bim_pkg::*;

  localparam int W   = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int DW  = (DIM_BITS < REG_BITS) ? DIM_BITS : REG_BITS;
  localparam int LAT = 2 * W + 3;

  logic [DW-1:0] od_eff     [MAX_RANK];
  logic [DW-1:0] sd_al      [MAX_RANK];
  logic [INDEX_BITS-1:0] out_stride [MAX_RANK];
  logic [W-1:0]  src_stride [MAX_RANK];
  logic          shape_err;
  logic          settling;
  logic [LAT-1:0] vld;
  logic [W-1:0]  ind_q;
  logic [W-1:0]  prod_q [MAX_RANK];
  logic [W-1:0]  sum;
  logic [W-1:0]  sum_q;
  logic [W+31:0] sum_ext;
  logic          err_q;

  bim_shape #(
    .MAX_RANK(MAX_RANK), .IB(INDEX_BITS), .W(W), .DW(DW)
  ) u_shape (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .od_eff, .sd_al, .out_stride, .src_stride, .shape_err, .settling
  );

  assign busy = settling;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LAT-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    ind_q <= flat_index[W-1:0];
  end

  for (genvar p = 0; p < MAX_RANK; p++) begin : g_lane
    logic [W-1:0]    q1;
    logic [W-1:0]    r1;
    logic [W-1:0]    q2;
    logic [DW-1:0]   r2;
    logic            zero;
    logic [W+DW-1:0] r2_ext;
    logic [W-1:0]    coord;
    logic [2*W-1:0]  prod;

    bim_div_pipe #(.N(W), .D(W)) u_div_stride (
      .clk, .dividend(ind_q), .divisor(out_stride[p][W-1:0]),
      .quotient(q1), .remainder(r1)
    );
    bim_div_pipe #(.N(W), .D(DW)) u_div_dim (
      .clk, .dividend(q1), .divisor(od_eff[p]),
      .quotient(q2), .remainder(r2)
    );

    // stride wrapped to 0 or beyond the index width, or source dim of 1: coordinate is 0
    assign zero   = (out_stride[p] == '0) || ((out_stride[p] >> W) != '0) ||
                    (sd_al[p] == DW'(1));
    assign r2_ext = {{W{1'b0}}, r2};
    assign coord  = zero ? '0 : r2_ext[W-1:0];
    assign prod   = coord * src_stride[p];

    always_ff @(posedge clk) begin
      prod_q[p] <= prod[W-1:0];
    end
  end

  always_comb begin
    sum = '0;
    for (int p = 0; p < MAX_RANK; p++) sum = sum + prod_q[p];
  end

  always_ff @(posedge clk) begin
    sum_q <= sum;
    err_q <= shape_err;
  end

  assign sum_ext      = {32'b0, sum_q};
  assign done         = vld[LAT-1];
  assign source_index = sum_ext[31:0];
  assign shape_error  = err_q;

endmodule

// File: src/bim_checker.sv
// Port-level checks for the broadcast index map.
module bim_checker #(
  parameter int INDEX_BITS = 32
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cfg_we,
  input logic done
);

  localparam int W   = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int LAT = 2 * W + 3;

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy) else $error("busy low after a register write");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !done) else $error("done right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done) else $error("item result missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT)) else $error("result without an item");

endmodule

bind broadcast_index_map_core bim_checker #(.INDEX_BITS(INDEX_BITS)) u_bim_checker (
  .clk, .rst, .start, .busy, .cfg_we, .done
);

// File: bench/tb_top.sv
// Testbench for broadcast_index_map_core: directed and random shapes and indexes checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import bim_pkg::*;

  localparam longint unsigned IDX_MASK = 64'hFFFF_FFFF;
  localparam int LATENCY = 67;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [31:0] source_index;
    logic        shape_error;
  } src_ref_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] flat_index = '0;
  logic        done;
  logic [31:0] source_index;
  logic        shape_error;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0]     cfg_data = '0;

  logic [15:0] out_shape [4];
  logic [15:0] src_shape [4];
  logic [31:0] pending_idx [$];
  src_ref_t    expected_src [$];
  int          gap = 0;
  bit          no_gaps = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  broadcast_index_map_core dut (
    .clk, .rst, .start, .busy, .flat_index, .done, .source_index, .shape_error,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic src_ref_t map_index(logic [31:0] idx);
    longint unsigned ostride, sstride, sidx, od, sd, coord;
    src_ref_t r;
    ostride = 1;
    sstride = 1;
    sidx = 0;
    r.shape_error = 1'b0;
    for (int p = 3; p >= 0; p--) begin
      od = out_shape[p];
      sd = src_shape[p];
      if (od == 0) od = 1;
      if (sd != 1 && sd != od) r.shape_error = 1'b1;
      coord = (ostride == 0) ? 0 : (longint'(idx) / ostride) % od;
      if (sd == 1) coord = 0;
      sidx = (sidx + coord * sstride) & IDX_MASK;
      ostride = (ostride * od) & IDX_MASK;
      sstride = (sstride * sd) & IDX_MASK;
    end
    r.source_index = sidx[31:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 90);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_src.push_back(map_index(flat_index));
      if (start && busy) begin
      end else if (gap > 0) begin
        gap = gap - 1;
        start <= 1'b0;
      end else if (pending_idx.size() > 0) begin
        flat_index <= pending_idx.pop_front();
        start <= 1'b1;
        gap = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    src_ref_t e;
    if (!rst && done) begin
      if (expected_src.size() == 0) begin
        $error("result with no item outstanding: source_index=%0h", source_index);
        errors++;
      end else begin
        e = expected_src.pop_front();
        if (source_index !== e.source_index) begin
          $error("source_index expected %0h actual %0h", e.source_index, source_index);
          errors++;
        end
        if (shape_error !== e.shape_error) begin
          $error("shape_error expected %0b actual %0b", e.shape_error, shape_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_idx.size() > 0 || start || expected_src.size() > 0) @(posedge clk);
  endtask

  task automatic load_shape(input logic [15:0] o0, o1, o2, o3, s0, s1, s2, s3);
    logic [15:0] v [8];
    v = '{o0, o1, o2, o3, s0, s1, s2, s3};
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_BITS'((i < 4) ? REG_OUT_DIM_0 + i : REG_SRC_DIM_0 + (i - 4));
      cfg_data <= v[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      out_shape[i] = v[i];
      src_shape[i] = v[i + 4];
    end
  endtask

  function automatic logic [15:0] rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 7));
    if (r < 85) return 16'($urandom_range(8, 300));
    if (r < 95) return 16'($urandom_range(0, 65535));
    return (r < 97) ? 16'd0 : 16'hFFFF;
  endfunction

  function automatic logic [15:0] rand_src(logic [15:0] od);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return od;
    if (r < 92) return 16'd1;
    if (r < 96) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] rand_idx(longint unsigned total);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && total > 1) return $urandom_range(0, 32'((total > 64'hFFFF_FFFF) ?
                                                  64'hFFFF_FFFF : total - 1));
    if (r < 9) return $urandom();
    return (r[0]) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  initial begin
    logic [15:0] o [4];
    logic [15:0] s [4];
    longint unsigned total;
    for (int i = 0; i < 4; i++) begin
      out_shape[i] = 16'd1;
      src_shape[i] = 16'd1;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset shape: everything maps to 0
    pending_idx = '{32'd0, 32'hFFFF_FFFF, 32'hA5A5_5A5A};
    load_shape(2, 3, 4, 5, 1, 3, 1, 5);
    pending_idx = '{32'd0, 32'd1, 32'd19, 32'd20, 32'd119, 32'd120, 32'hFFFF_FFFF};
    // maximal dims, then zero dims on both sides
    load_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF);
    pending_idx = '{32'd0, 32'hFFFF_FFFF, 32'h5555_AAAA};
    load_shape(0, 3, 0, 4, 1, 0, 1, 4);
    pending_idx = '{32'd7, 32'd11, 32'hFFFF_FFFE};
    // mismatched source dims; output stride wrapping to zero
    load_shape(3, 5, 6, 7, 2, 9, 6, 1);
    pending_idx = '{32'd100, 32'd629};
    load_shape(9, 4, 16'h8000, 16'h8000, 9, 4, 1, 16'h8000);
    pending_idx = '{32'hFFFF_FFFF, 32'h1234_5678};

    for (int ph = 0; ph < 12; ph++) begin
      for (int i = 0; i < 4; i++) begin
        o[i] = rand_dim();
        s[i] = rand_src(o[i]);
      end
      load_shape(o[0], o[1], o[2], o[3], s[0], s[1], s[2], s[3]);
      no_gaps = (ph % 4 == 1);
      total = 1;
      for (int i = 0; i < 4; i++) total = total * ((o[i] == 0) ? 1 : o[i]);
      for (int n = 0; n < 110; n++) pending_idx.push_back(rand_idx(total));
    end

    wait_idle();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bim_pkg.sv
src/bim_div_pipe.sv
src/bim_shape.sv
src/broadcast_index_map_core.sv
src/bim_checker.sv
bench/tb_top.sv
